>>> hw/rtl/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue assertion failed");

`endif

>>> hw/rtl/spq_pkg.sv
// Types, codes and helpers shared by the sorted priority queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [1:0] CMD_HOLD  = 2'd0;
   localparam logic [1:0] CMD_PUSH  = 2'd1;
   localparam logic [1:0] CMD_POP   = 2'd2;
   localparam logic [1:0] CMD_SHIFT = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        tag;
      logic signed [15:0] prio;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        popped_tag;
      logic signed [15:0] popped_prio;
      logic [4:0]         removed_count;
      logic               head_valid;
      logic [15:0]        head_tag;
      logic signed [15:0] head_prio;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [15:0]        tag;
      logic signed [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic [1:0]         code;
      logic [15:0]        tag;
      logic signed [15:0] prio;
   } cmd_type;

   function automatic logic [4:0] sat_count(input logic [31:0] value);
      logic [4:0] result;
      if (value > 32'd31) begin
         result = 5'd31;
      end else begin
         result = value[4:0];
      end
      return result;
   endfunction

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_pos,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               pos_flag,
   output logic               match
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               at_or_above;

   assign pos_flag    = !entry_ff.valid || (entry_ff.prio > cmd.prio);
   assign at_or_above = !entry_ff.valid || (entry_ff.prio >= cmd.prio);
   assign match       = entry_ff.valid && (entry_ff.prio == cmd.prio);
   assign entry       = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.code)
         spq_pkg::CMD_PUSH: begin
            if (left_pos) begin
               entry_in = left_entry;
            end else if (pos_flag) begin
               entry_in.valid = 1'b1;
               entry_in.tag   = cmd.tag;
               entry_in.prio  = cmd.prio;
            end
         end
         spq_pkg::CMD_POP: begin
            entry_in = right_entry;
         end
         spq_pkg::CMD_SHIFT: begin
            if (at_or_above) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of entry cells kept in ascending priority order.
// Push and pop shift the chain by one cell in the accept cycle, and the result
// is built from the head cell in the next. For remove, the matching entries
// form one run, and the chain shifts left by one cell per cycle until no cell
// matches; remove on an empty queue goes straight to building the result.
// A request is taken only when the previous one has been handed to the result
// register; a result waiting there blocks only the finishing cycle of the next
// request.
module sorted_priority_queue_unit #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   `include "sorted_priority_queue_unit_assert.svh"

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REMOVE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   spq_pkg::entry_type cell_entry [DEPTH];
   logic [DEPTH-1:0]   cell_pos;
   logic [DEPTH-1:0]   cell_match;
   spq_pkg::cmd_type   cmd;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rm_cnt_ff, rm_cnt_in;
   logic [1:0]         status_ff, status_in;
   logic signed [15:0] key_ff, key_in;
   logic [15:0]        ptag_ff, ptag_in;
   logic signed [15:0] pprio_ff, pprio_in;
   logic               rsp_valid_ff;
   spq_pkg::rsp_type   rsp_data_ff;
   spq_pkg::rsp_type   rsp_next;

   logic accept;
   logic full;
   logic empty;
   logic hit;
   logic out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = cell_entry[DEPTH-1].valid;
   assign empty     = !cell_entry[0].valid;
   assign hit       = |cell_match;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cmd.code = spq_pkg::CMD_HOLD;
      cmd.tag  = req_data.tag;
      cmd.prio = (state_ff == ST_REMOVE) ? key_ff : req_data.prio;
      if (accept) begin
         case (req_data.action)
            spq_pkg::ACT_PUSH: begin
               if (!full) begin
                  cmd.code = spq_pkg::CMD_PUSH;
               end
            end
            spq_pkg::ACT_POP: begin
               if (!empty) begin
                  cmd.code = spq_pkg::CMD_POP;
               end
            end
            default: begin
               cmd.code = spq_pkg::CMD_HOLD;
            end
         endcase
      end else if ((state_ff == ST_REMOVE) && hit) begin
         cmd.code = spq_pkg::CMD_SHIFT;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_pos;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_pos   = 1'b0;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
         assign left_pos   = cell_pos[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_pos    (left_pos),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .pos_flag    (cell_pos[i]),
         .match       (cell_match[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rm_cnt_in = rm_cnt_ff;
      status_in = status_ff;
      key_in    = key_ff;
      ptag_in   = ptag_ff;
      pprio_in  = pprio_ff;

      case (cmd.code)
         spq_pkg::CMD_PUSH:  count_in = count_ff + 1'b1;
         spq_pkg::CMD_POP:   count_in = count_ff - 1'b1;
         spq_pkg::CMD_SHIFT: count_in = count_ff - 1'b1;
         default:            count_in = count_ff;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in    = req_data.prio;
               rm_cnt_in = '0;
               status_in = spq_pkg::STATUS_OK;
               ptag_in   = '0;
               pprio_in  = '0;
               state_in  = ST_FINISH;
               case (req_data.action)
                  spq_pkg::ACT_PUSH: begin
                     if (full) begin
                        status_in = spq_pkg::STATUS_FULL;
                     end
                  end
                  spq_pkg::ACT_POP: begin
                     if (empty) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        ptag_in  = cell_entry[0].tag;
                        pprio_in = cell_entry[0].prio;
                     end
                  end
                  spq_pkg::ACT_REMOVE: begin
                     if (empty) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_REMOVE;
                     end
                  end
                  default: begin
                     status_in = spq_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            if (hit) begin
               rm_cnt_in = rm_cnt_ff + 1'b1;
            end else begin
               state_in = ST_FINISH;
               if (rm_cnt_ff == '0) begin
                  status_in = spq_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_next.status        = status_ff;
      rsp_next.popped_tag    = ptag_ff;
      rsp_next.popped_prio   = pprio_ff;
      rsp_next.removed_count = spq_pkg::sat_count(32'(rm_cnt_ff));
      rsp_next.head_valid    = cell_entry[0].valid;
      rsp_next.head_tag      = cell_entry[0].valid ? cell_entry[0].tag : '0;
      rsp_next.head_prio     = cell_entry[0].valid ? cell_entry[0].prio : '0;
      rsp_next.occupancy     = spq_pkg::sat_count(32'(count_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rm_cnt_ff <= rm_cnt_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      ptag_ff   <= ptag_in;
      pprio_ff  <= pprio_in;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_data_ff <= rsp_next;
      end
   end

   `SPQ_ASSERT_IMPL(a_empty_matches_count, clock, reset, 1'b1, (count_ff == '0) == empty)
   `SPQ_ASSERT_IMPL(a_full_matches_count, clock, reset, 1'b1, (count_ff == CW'(DEPTH)) == full)
   `SPQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd.code == spq_pkg::CMD_PUSH, count_ff == $past(count_ff) + 1'b1)
   `SPQ_ASSERT_NEXT(a_shift_shrinks, clock, reset, cmd.code == spq_pkg::CMD_SHIFT, count_ff == $past(count_ff) - 1'b1)

endmodule

>>> bench/sorted_priority_queue_unit_tb.sv
// Testbench for the sorted priority queue: scoreboard against a behavioral queue model.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;

   localparam int DEPTH = spq_pkg::DEPTH_DEFAULT;
   localparam logic [1:0] ACT_NOP = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      spq_pkg::req_type req;
      logic             drain;
   } backlog_item_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spq_pkg::rsp_type rsp_data;

   backlog_item_type   req_backlog[$];
   spq_pkg::rsp_type   due_results[$];
   logic signed [15:0] shadow_prio[DEPTH];
   logic [15:0]        shadow_tag[DEPTH];
   int                 shadow_fill = 0;

   logic        bench_idle = 1'b1;
   int          burst_left = 0;
   int          gap_left = 0;
   int          req_taken = 0;
   int          rsp_checked = 0;
   int          rsp_taken = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          hold_left = 0;
   int          hold_at = 120;
   int          long_holds = 0;
   int          pattern_age = 0;
   logic [15:0] stall_bits = '0;
   int          n_push = 0, n_pop = 0, n_remove = 0, n_nop = 0;
   int          n_full = 0, n_empty = 0, n_not_found = 0;
   int          widest_remove = 0, peak_fill = 0;

   sorted_priority_queue_unit #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic spq_pkg::rsp_type apply_queue_action(input spq_pkg::req_type r);
      spq_pkg::rsp_type res;
      int               pos;
      int               gone;
      int               keep;
      int               i;
      res = '0;
      case (r.action)
         spq_pkg::ACT_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = spq_pkg::STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_fill && shadow_prio[pos] <= r.prio) pos++;
               for (i = shadow_fill; i > pos; i--) begin
                  shadow_prio[i] = shadow_prio[i - 1];
                  shadow_tag[i] = shadow_tag[i - 1];
               end
               shadow_prio[pos] = r.prio;
               shadow_tag[pos] = r.tag;
               shadow_fill++;
            end
         end
         spq_pkg::ACT_POP: begin
            if (shadow_fill == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               res.popped_tag = shadow_tag[0];
               res.popped_prio = shadow_prio[0];
               for (i = 1; i < shadow_fill; i++) begin
                  shadow_prio[i - 1] = shadow_prio[i];
                  shadow_tag[i - 1] = shadow_tag[i];
               end
               shadow_fill--;
            end
         end
         spq_pkg::ACT_REMOVE: begin
            if (shadow_fill == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               gone = 0;
               keep = 0;
               for (i = 0; i < shadow_fill; i++) begin
                  if (shadow_prio[i] == r.prio) begin
                     gone++;
                  end else begin
                     shadow_prio[keep] = shadow_prio[i];
                     shadow_tag[keep] = shadow_tag[i];
                     keep++;
                  end
               end
               shadow_fill = keep;
               if (gone == 0) res.status = spq_pkg::STATUS_NOT_FOUND;
               res.removed_count = (gone > 31) ? 5'd31 : gone[4:0];
            end
         end
         default: begin
         end
      endcase
      if (shadow_fill > 0) begin
         res.head_valid = 1'b1;
         res.head_tag = shadow_tag[0];
         res.head_prio = shadow_prio[0];
      end
      res.occupancy = (shadow_fill > 31) ? 5'd31 : shadow_fill[4:0];
      return res;
   endfunction

   function automatic string show_rsp(input spq_pkg::rsp_type r);
      return $sformatf({"status=%0d popped=%h/%0d removed=%0d ",
                        "head=%b/%h/%0d occupancy=%0d"},
                       r.status, r.popped_tag, r.popped_prio, r.removed_count,
                       r.head_valid, r.head_tag, r.head_prio, r.occupancy);
   endfunction

   function automatic logic signed [15:0] pick_prio();
      logic signed [15:0] pool[8];
      pool = '{-16'sd32768, -16'sd100, -16'sd1, 16'sd0, 16'sd1, 16'sd5, 16'sd100, 16'sd32767};
      if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   task automatic add_req(input logic [1:0] action, input logic [15:0] tag,
                          input logic signed [15:0] prio, input logic drain);
      backlog_item_type item;
      item.req.action = action;
      item.req.tag = tag;
      item.req.prio = prio;
      item.drain = drain;
      req_backlog.push_back(item);
   endtask

   task automatic new_burst();
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic             take;
      backlog_item_type item;
      take = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         new_burst();
      end else if (!(req_valid && req_stall)) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].drain && (take || !bench_idle))) begin
            item = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_data <= item.req;
            if (burst_left <= 1) begin
               new_burst();
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern and long hold
   always @(posedge clock) begin : receive
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_taken++;
         if (pattern_age == 0) begin
            pattern_age = 48;
            case ($urandom_range(0, 3))
               0: stall_bits = '0;
               1: stall_bits = 16'($urandom);
               2: stall_bits = 16'($urandom | $urandom);
               default: stall_bits = 16'($urandom & $urandom);
            endcase
         end
         pattern_age--;
         stall_bits = {stall_bits[0], stall_bits[15:1]};
         stall_next = stall_bits[0];
         if (hold_left == 0 && rsp_taken >= hold_at) begin
            hold_left = LONG_HOLD;
            hold_at += 500;
            long_holds++;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end
         rsp_stall <= stall_next;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : watch
      spq_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected result: %s", $time, show_rsp(rsp_data));
            end else begin
               want = due_results.pop_front();
               rsp_checked++;
               if (rsp_data.status !== want.status ||
                   rsp_data.popped_tag !== want.popped_tag ||
                   rsp_data.popped_prio !== want.popped_prio ||
                   rsp_data.removed_count !== want.removed_count ||
                   rsp_data.head_valid !== want.head_valid ||
                   rsp_data.head_tag !== want.head_tag ||
                   rsp_data.head_prio !== want.head_prio ||
                   rsp_data.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] mismatch on result %0d", $time, rsp_checked);
                     $display("   expected %s", show_rsp(want));
                     $display("   actual   %s", show_rsp(rsp_data));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_queue_action(req_data);
            due_results.push_back(want);
            req_taken++;
            case (req_data.action)
               spq_pkg::ACT_PUSH:   n_push++;
               spq_pkg::ACT_POP:    n_pop++;
               spq_pkg::ACT_REMOVE: n_remove++;
               default:             n_nop++;
            endcase
            case (want.status)
               spq_pkg::STATUS_FULL:      n_full++;
               spq_pkg::STATUS_EMPTY:     n_empty++;
               spq_pkg::STATUS_NOT_FOUND: n_not_found++;
               default: begin
               end
            endcase
            if (int'(want.removed_count) > widest_remove)
               widest_remove = int'(want.removed_count);
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         end
         bench_idle <= (due_results.size() == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic signed [15:0] seed_prio[16];
      int                 total;
      int                 counted;
      int                 mode;
      int                 len;
      int                 roll;
      int                 i;
      logic [1:0]         action;
      seed_prio = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd5, 16'sd5, -16'sd1, 16'sd5, 16'sd0,
                    16'sd32767, -16'sd32768, 16'sd100, -16'sd100, 16'sd5, 16'sd1, 16'sd2,
                    16'sd3};

      add_req(spq_pkg::ACT_POP, 16'h0000, 16'sd0, 1'b0);
      add_req(spq_pkg::ACT_REMOVE, 16'hFFFF, 16'sd0, 1'b0);
      add_req(ACT_NOP, 16'hFFFF, -16'sd1, 1'b0);
      add_req(spq_pkg::ACT_PUSH, 16'h0000, seed_prio[0], 1'b0);
      add_req(spq_pkg::ACT_PUSH, 16'hFFFF, seed_prio[1], 1'b0);
      for (i = 2; i < 16; i++)
         add_req(spq_pkg::ACT_PUSH, 16'(16'h1000 + i), seed_prio[i], 1'b0);
      add_req(spq_pkg::ACT_PUSH, 16'hAAAA, 16'sd0, 1'b0);
      add_req(spq_pkg::ACT_REMOVE, 16'h5555, 16'sd5, 1'b0);
      add_req(spq_pkg::ACT_REMOVE, 16'h0000, 16'sd77, 1'b0);
      add_req(spq_pkg::ACT_POP, 16'h0000, 16'sd0, 1'b0);
      add_req(spq_pkg::ACT_POP, 16'h0000, 16'sd0, 1'b0);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         len = $urandom_range(15, 60);
         for (i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               0:       action = (roll < 70) ? spq_pkg::ACT_PUSH :
                                 (roll < 82) ? spq_pkg::ACT_POP :
                                 (roll < 96) ? spq_pkg::ACT_REMOVE : ACT_NOP;
               1:       action = (roll < 20) ? spq_pkg::ACT_PUSH :
                                 (roll < 80) ? spq_pkg::ACT_POP :
                                 (roll < 96) ? spq_pkg::ACT_REMOVE : ACT_NOP;
               default: action = (roll < 45) ? spq_pkg::ACT_PUSH :
                                 (roll < 75) ? spq_pkg::ACT_POP :
                                 (roll < 96) ? spq_pkg::ACT_REMOVE : ACT_NOP;
            endcase
            add_req(action, 16'($urandom), pick_prio(),
                    i == 0 && (counted == 0 || $urandom_range(0, 3) == 0));
            if (action != ACT_NOP) counted++;
         end
      end
      total = req_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_taken != total) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (due_results.size() != 0) begin
         mismatch_count += due_results.size();
         $display("%0d expected results never arrived", due_results.size());
      end
      $display("Run: %0d requests (%0d push, %0d pop, %0d remove, %0d no-op), ",
               req_taken, n_push, n_pop, n_remove, n_nop,
               "%0d results checked, %0d mismatches, %0d long receiver holds",
               rsp_checked, mismatch_count, long_holds);
      $display("Cases: %0d dropped on full, %0d on empty, %0d priority not found, ",
               n_full, n_empty, n_not_found,
               "widest remove %0d, peak occupancy %0d", widest_remove, peak_fill);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
